// ----- hw/rtl/mcms_pkg.sv -----
// ----------------------------------------------------------------------------
// mcms_pkg
// Shared sizes and types for the median common-mode subtraction block.
// ----------------------------------------------------------------------------
package mcms_pkg;

   localparam int GROUP_SIZE = 128;
   localparam int PAIR_COUNT = GROUP_SIZE / 2;
   localparam int PAIR_W     = $clog2(PAIR_COUNT);
   localparam int RANK_W     = $clog2(GROUP_SIZE);
   localparam int CNT_W      = $clog2(GROUP_SIZE + 1);
   localparam int SAMPLE_W   = 16;
   localparam int RANK_LO    = PAIR_COUNT - 1;
   localparam int RANK_HI    = PAIR_COUNT;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [SAMPLE_W-1:0]        key_type;

   localparam key_type SIGN_FLIP = {1'b1, {(SAMPLE_W-1){1'b0}}};

endpackage

// ----- hw/rtl/mcms_if.sv -----
// ----------------------------------------------------------------------------
// mcms_if
// Valid/ready channels for sample pair words and corrected pair words.
// ----------------------------------------------------------------------------
interface mcms_req_if;
   import mcms_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_even;
   sample_type sample_odd;

   modport source (output valid, output sample_even, output sample_odd, input ready);
   modport sink   (input valid, input sample_even, input sample_odd, output ready);
endinterface

interface mcms_rsp_if;
   import mcms_pkg::*;

   logic       valid;
   logic       ready;
   sample_type corrected_even;
   sample_type corrected_odd;
   logic       group_end;

   modport source (output valid, output corrected_even, output corrected_odd,
                   output group_end, input ready);
   modport sink   (input valid, input corrected_even, input corrected_odd,
                   input group_end, output ready);
endinterface

// ----- hw/rtl/median_common_mode_subtract.sv -----
// ----------------------------------------------------------------------------
// median_common_mode_subtract
// Median baseline removal over groups of 128 signed samples.
// ----------------------------------------------------------------------------
// Collects a group of 128 samples, two per input word, in a 64-entry pair
// store with one read port. After the last pair the median (mean of ranks 63
// and 64) is found by a bitwise radix search: 16 passes, one per sample bit
// from the top, each sweeping all 64 stored pairs and tracking both ranks
// at once. The block then returns each pair minus the median, truncated
// toward zero and saturated, in arrival order, with group_end on the last;
// each pair is read and its output word formed before the next pair is read.
// Input ready is high only while the group is being loaded; the final output
// word may still wait while loading resumes.
// ----------------------------------------------------------------------------
module median_common_mode_subtract (
   input logic       clock,
   input logic       reset,
   mcms_req_if.sink  req,
   mcms_rsp_if.source rsp
);
   import mcms_pkg::*;

   localparam logic [1:0] ST_LOAD   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_SETTLE = 2'd2;
   localparam logic [1:0] ST_OUT    = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [PAIR_W-1:0]     pairs_ff, pairs_in;
   logic [PAIR_W-1:0]     addr_ff, addr_in;
   logic                  pend_ff, pend_in;
   logic                  last_ff, last_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [2*SAMPLE_W-1:0] rd_data_ff;
   logic [2*SAMPLE_W-1:0] store_mem [PAIR_COUNT];

   key_type               sel_ff, sel_in;
   key_type               mask_ff, mask_in;
   key_type               pref_lo_ff, pref_lo_in;
   key_type               pref_hi_ff, pref_hi_in;
   logic [RANK_W-1:0]     rank_lo_ff, rank_lo_in;
   logic [RANK_W-1:0]     rank_hi_ff, rank_hi_in;
   logic [CNT_W-1:0]      cnt_lo_ff, cnt_lo_in;
   logic [CNT_W-1:0]      cnt_hi_ff, cnt_hi_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   sample_type            rsp_even_ff, rsp_even_in;
   sample_type            rsp_odd_ff, rsp_odd_in;
   logic                  rsp_end_ff, rsp_end_in;

   logic                  req_take;
   logic                  out_issue;
   key_type               key_even, key_odd;
   logic [1:0]            inc_lo, inc_hi;
   logic [CNT_W-1:0]      tot_lo, tot_hi;
   key_type               val_lo, val_hi;
   logic signed [SAMPLE_W:0] med2;

   function automatic logic zero_hit(key_type key, key_type pref, key_type mask,
                                     key_type sel);
      zero_hit = (((key ^ pref) & mask) == '0) && ((key & sel) == '0);
   endfunction

   function automatic sample_type correct(sample_type x, logic signed [SAMPLE_W:0] m2);
      logic signed [SAMPLE_W+1:0] diff;
      logic signed [SAMPLE_W+1:0] adj;
      logic [SAMPLE_W:0]          q;
      diff = {x[SAMPLE_W-1], x, 1'b0} - {m2[SAMPLE_W], m2};
      adj  = diff + (SAMPLE_W+2)'(diff[SAMPLE_W+1] & diff[0]);
      q    = adj[SAMPLE_W+1:1];
      if (q[SAMPLE_W] != q[SAMPLE_W-1]) begin
         correct = q[SAMPLE_W] ? sample_type'(SIGN_FLIP) : sample_type'(~SIGN_FLIP);
      end else begin
         correct = q[SAMPLE_W-1:0];
      end
   endfunction

   assign req_take  = req.valid && req.ready;
   assign req.ready = (state_ff == ST_LOAD);
   assign out_issue = (state_ff == ST_OUT) && !pend_ff && (!rsp_valid_ff || rsp.ready);

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.corrected_even = rsp_even_ff;
   assign rsp.corrected_odd  = rsp_odd_ff;
   assign rsp.group_end      = rsp_end_ff;

   // bitwise rank search on offset-binary keys
   assign key_even = rd_data_ff[SAMPLE_W-1:0] ^ SIGN_FLIP;
   assign key_odd  = rd_data_ff[2*SAMPLE_W-1:SAMPLE_W] ^ SIGN_FLIP;
   assign inc_lo   = rd_valid_ff ? (2'(zero_hit(key_even, pref_lo_ff, mask_ff, sel_ff))
                                  + 2'(zero_hit(key_odd, pref_lo_ff, mask_ff, sel_ff)))
                                 : 2'd0;
   assign inc_hi   = rd_valid_ff ? (2'(zero_hit(key_even, pref_hi_ff, mask_ff, sel_ff))
                                  + 2'(zero_hit(key_odd, pref_hi_ff, mask_ff, sel_ff)))
                                 : 2'd0;
   assign tot_lo   = cnt_lo_ff + CNT_W'(inc_lo);
   assign tot_hi   = cnt_hi_ff + CNT_W'(inc_hi);

   // doubled median
   assign val_lo = pref_lo_ff ^ SIGN_FLIP;
   assign val_hi = pref_hi_ff ^ SIGN_FLIP;
   assign med2   = $signed({val_lo[SAMPLE_W-1], val_lo}) + $signed({val_hi[SAMPLE_W-1], val_hi});

   always_comb begin
      state_in     = state_ff;
      pairs_in     = pairs_ff;
      addr_in      = addr_ff;
      pend_in      = 1'b0;
      last_in      = last_ff;
      rd_valid_in  = (state_ff == ST_SCAN);
      sel_in       = sel_ff;
      mask_in      = mask_ff;
      pref_lo_in   = pref_lo_ff;
      pref_hi_in   = pref_hi_ff;
      rank_lo_in   = rank_lo_ff;
      rank_hi_in   = rank_hi_ff;
      cnt_lo_in    = cnt_lo_ff;
      cnt_hi_in    = cnt_hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_even_in  = rsp_even_ff;
      rsp_odd_in   = rsp_odd_ff;
      rsp_end_in   = rsp_end_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               pairs_in = pairs_ff + PAIR_W'(1);
               if (pairs_ff == PAIR_W'(PAIR_COUNT - 1)) begin
                  pairs_in   = '0;
                  state_in   = ST_SCAN;
                  addr_in    = '0;
                  sel_in     = SIGN_FLIP;
                  mask_in    = '0;
                  pref_lo_in = '0;
                  pref_hi_in = '0;
                  rank_lo_in = RANK_W'(RANK_LO);
                  rank_hi_in = RANK_W'(RANK_HI);
                  cnt_lo_in  = '0;
                  cnt_hi_in  = '0;
               end
            end
         end
         ST_SCAN: begin
            cnt_lo_in = tot_lo;
            cnt_hi_in = tot_hi;
            addr_in   = addr_ff + PAIR_W'(1);
            if (addr_ff == PAIR_W'(PAIR_COUNT - 1)) begin
               addr_in  = '0;
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            cnt_lo_in = '0;
            cnt_hi_in = '0;
            if (CNT_W'(rank_lo_ff) >= tot_lo) begin
               pref_lo_in = pref_lo_ff | sel_ff;
               rank_lo_in = rank_lo_ff - RANK_W'(tot_lo);
            end
            if (CNT_W'(rank_hi_ff) >= tot_hi) begin
               pref_hi_in = pref_hi_ff | sel_ff;
               rank_hi_in = rank_hi_ff - RANK_W'(tot_hi);
            end
            sel_in  = sel_ff >> 1;
            mask_in = {1'b1, mask_ff[SAMPLE_W-1:1]};
            if (sel_ff[0]) begin
               state_in = ST_OUT;
               addr_in  = '0;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_OUT: begin
            if (out_issue) begin
               pend_in = 1'b1;
               last_in = (addr_ff == PAIR_W'(PAIR_COUNT - 1));
               addr_in = addr_ff + PAIR_W'(1);
            end
            if (pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_even_in  = correct(rd_data_ff[SAMPLE_W-1:0], med2);
               rsp_odd_in   = correct(rd_data_ff[2*SAMPLE_W-1:SAMPLE_W], med2);
               rsp_end_in   = last_ff;
               if (last_ff) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // pair store
   always_ff @(posedge clock) begin
      if (req_take) begin
         store_mem[pairs_ff] <= {req.sample_odd, req.sample_even};
      end
      rd_data_ff <= store_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         pairs_ff     <= '0;
         pend_ff      <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pairs_ff     <= pairs_in;
         pend_ff      <= pend_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      last_ff     <= last_in;
      sel_ff      <= sel_in;
      mask_ff     <= mask_in;
      pref_lo_ff  <= pref_lo_in;
      pref_hi_ff  <= pref_hi_in;
      rank_lo_ff  <= rank_lo_in;
      rank_hi_ff  <= rank_hi_in;
      cnt_lo_ff   <= cnt_lo_in;
      cnt_hi_ff   <= cnt_hi_in;
      rsp_even_ff <= rsp_even_in;
      rsp_odd_ff  <= rsp_odd_in;
      rsp_end_ff  <= rsp_end_in;
   end

endmodule
